FILE: sv/rgb_to_hsl_converter_assert.svh
// ----------------------------------------------------------------------------
// RGB to HSL converter assertion macros
// Property wrappers used by the converter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define RTOH_ASSERT_NOW(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define RTOH_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/rtoh_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter package
// Widths, codes, shared types and the restoring divider step.
// ----------------------------------------------------------------------------
`default_nettype none

package rtoh_pkg;

	localparam int HUE_FRAC_BITS = 8;
	localparam int HUE_STEPS     = 1 << HUE_FRAC_BITS;

	// Quotient width covers both the hue fraction (up to HUE_STEPS) and saturation.
	localparam int DIV_QW    = (HUE_FRAC_BITS + 1 > 8) ? HUE_FRAC_BITS + 1 : 8;
	localparam int DIV_XW    = 8 + DIV_QW;
	localparam int HUE_W     = (HUE_FRAC_BITS + 4 > 11) ? HUE_FRAC_BITS + 4 : 11;
	localparam int DIV_LANES = 2;

	localparam int LANE_HUE = 0;
	localparam int LANE_SAT = 1;

	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	localparam logic [8:0] FULL_SCALE = 9'd255;
	localparam logic [8:0] SUM_MAX    = 9'd510;

	localparam logic [HUE_W-1:0] BASE_GREEN = HUE_W'(2 * HUE_STEPS);
	localparam logic [HUE_W-1:0] BASE_BLUE  = HUE_W'(4 * HUE_STEPS);
	localparam logic [HUE_W-1:0] BASE_WRAP  = HUE_W'(6 * HUE_STEPS);

	typedef struct packed {
		logic [DIV_XW-1:0] x;
		logic [7:0]        d;
	} div_lane_t;

	typedef struct packed {
		logic [7:0]        rem;
		logic [DIV_QW-1:0] xq;
	} div_state_t;

	typedef struct packed {
		logic             grey;
		logic             neg;
		logic [HUE_W-1:0] base;
		logic [8:0]       sum;
	} side_t;

	function automatic div_state_t div_step(input div_state_t cur, input logic [7:0] d);
		logic [8:0] t;
		div_state_t nxt;
		t = {cur.rem, cur.xq[DIV_QW-1]};
		if (t >= {1'b0, d}) begin
			nxt.rem = 8'(t - {1'b0, d});
			nxt.xq  = {cur.xq[DIV_QW-2:0], 1'b1};
		end else begin
			nxt.rem = t[7:0];
			nxt.xq  = {cur.xq[DIV_QW-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

`default_nettype wire

FILE: sv/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter
// Converts one 8-bit RGB pixel per clock, unless the output stalls, into fixed-point
// hue, saturation and lightness sum.
//
//   channel  direction  handshake                    payload
//   pixel    in         pixel_valid / pixel_ready    red, green, blue
//   result   out        result_valid / result_ready  hue, saturation, lightness_sum
//
// One pixel is taken in every cycle unless the output stalls. Each pixel passes
// through stage 1, stage 2, the divider stages and the final stage register
// before its result is presented, and it transfers when result_ready is high.
// The latency is set by the divider pipeline, which resolves one quotient bit
// per stage for hue and saturation side by side.
// Reset clears all stage valid bits; no result is presented until a pixel arrives.
// A stall at the output holds only the stages behind it that are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rgb_to_hsl_converter_assert.svh"

module rgb_to_hsl_converter import rtoh_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        pixel_valid,
	output logic             pixel_ready,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [10:0]      hue,
	output logic [7:0]       saturation,
	output logic [8:0]       lightness_sum
);

	logic                               vld_s1, vld_s2, vld_s3;
	logic                               rdy_s1, rdy_s2, rdy_s3;
	logic [1:0]                         sec_s1;
	logic [7:0]                         chroma_s1;
	logic [8:0]                         sum_s1;
	logic signed [8:0]                  num_s1;
	div_lane_t [DIV_LANES-1:0]          lane_s2;
	side_t                              side_s2;
	logic [10:0]                        hue_s3;
	logic [7:0]                         sat_s3;
	logic [8:0]                         sum_s3;

	logic                               div_in_ready, div_out_valid;
	logic [DIV_LANES-1:0][DIV_QW-1:0]   div_q;
	side_t                              div_side;

	logic [1:0]                         sec_c;
	logic [7:0]                         mx_c, mn_c;
	logic signed [8:0]                  num_c;
	logic                               neg_c;
	logic [7:0]                         mag_c;
	logic [8:0]                         den_c;
	logic [HUE_W-1:0]                   base_c;
	logic [HUE_W-1:0]                   hue_full_c;
	div_lane_t [DIV_LANES-1:0]          lane_c;

	assign rdy_s3      = !vld_s3 || result_ready;
	assign rdy_s2      = !vld_s2 || div_in_ready;
	assign rdy_s1      = !vld_s1 || rdy_s2;
	assign pixel_ready = rdy_s1;

	// Stage 1: maximum, minimum and the signed difference of the other two channels.
	always_comb begin
		if (red >= green && red >= blue) begin
			sec_c = SEC_RED;
			mx_c  = red;
			mn_c  = (green < blue) ? green : blue;
			num_c = $signed({1'b0, green}) - $signed({1'b0, blue});
		end else if (green >= blue) begin
			sec_c = SEC_GREEN;
			mx_c  = green;
			mn_c  = (red < blue) ? red : blue;
			num_c = $signed({1'b0, blue}) - $signed({1'b0, red});
		end else begin
			sec_c = SEC_BLUE;
			mx_c  = blue;
			mn_c  = (red < green) ? red : green;
			num_c = $signed({1'b0, red}) - $signed({1'b0, green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			sec_s1    <= sec_c;
			chroma_s1 <= mx_c - mn_c;
			sum_s1    <= {1'b0, mx_c} + {1'b0, mn_c};
			num_s1    <= num_c;
		end
	end

	// Stage 2: dividends, divisors and the hue sector base.
	// A negative difference is divided with rounding up, giving the floor of the negative.
	always_comb begin
		neg_c = num_s1[8];
		mag_c = neg_c ? 8'(-num_s1) : num_s1[7:0];
		den_c = (sum_s1 >= FULL_SCALE) ? (SUM_MAX - sum_s1) : sum_s1;
		case (sec_s1)
			SEC_RED:   base_c = neg_c ? BASE_WRAP : '0;
			SEC_GREEN: base_c = BASE_GREEN;
			SEC_BLUE:  base_c = BASE_BLUE;
			default:   base_c = '0;
		endcase
		lane_c[LANE_HUE].x = DIV_XW'({mag_c, {HUE_FRAC_BITS{1'b0}}})
			+ (neg_c ? (DIV_XW'(chroma_s1) - DIV_XW'(1)) : '0);
		lane_c[LANE_HUE].d = chroma_s1;
		lane_c[LANE_SAT].x = DIV_XW'({chroma_s1, 8'd0}) - DIV_XW'(chroma_s1);
		lane_c[LANE_SAT].d = den_c[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			lane_s2       <= lane_c;
			side_s2.grey  <= (chroma_s1 == 8'd0);
			side_s2.neg   <= neg_c;
			side_s2.base  <= base_c;
			side_s2.sum   <= sum_s1;
		end
	end

	rtoh_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld_s2),
		.up_ready (div_in_ready),
		.up_lane  (lane_s2),
		.up_side  (side_s2),
		.dn_valid (div_out_valid),
		.dn_ready (rdy_s3),
		.dn_q     (div_q),
		.dn_side  (div_side)
	);

	// Final stage: combine sector base with the quotient and clear grey pixels.
	assign hue_full_c = div_side.neg
		? (div_side.base - HUE_W'(div_q[LANE_HUE]))
		: (div_side.base + HUE_W'(div_q[LANE_HUE]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (rdy_s3) begin
			vld_s3 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			hue_s3 <= div_side.grey ? 11'd0 : hue_full_c[10:0];
			sat_s3 <= div_side.grey ? 8'd0 : div_q[LANE_SAT][7:0];
			sum_s3 <= div_side.sum;
		end
	end

	assign result_valid  = vld_s3;
	assign hue           = hue_s3;
	assign saturation    = sat_s3;
	assign lightness_sum = sum_s3;

	`RTOH_ASSERT_NOW(a_sat_mid_light, clk, arst_n,
		result_valid && saturation != 8'd0,
		lightness_sum != 9'd0 && lightness_sum != SUM_MAX,
		"Saturation is non-zero for a black or white pixel.")

	`RTOH_ASSERT_NOW(a_hue_needs_chroma, clk, arst_n,
		result_valid && hue != 11'd0,
		saturation != 8'd0,
		"Hue is non-zero while saturation is zero.")

	`RTOH_ASSERT_NEXT(a_s2_holds, clk, arst_n,
		vld_s2 && !div_in_ready,
		vld_s2,
		"Stage two dropped a pixel while the divider was stalled.")

endmodule

`default_nettype wire

FILE: sv/rtoh_div.sv
// ----------------------------------------------------------------------------
// RGB to HSL converter divider pipeline
// Two-lane restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module rtoh_div import rtoh_pkg::*; (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           up_valid,
	output logic                                up_ready,
	input  wire div_lane_t [DIV_LANES-1:0]      up_lane,
	input  wire side_t                          up_side,
	output logic                                dn_valid,
	input  wire logic                           dn_ready,
	output logic [DIV_LANES-1:0][DIV_QW-1:0]    dn_q,
	output side_t                               dn_side
);

	logic [DIV_QW-1:0]                      vld_s;
	logic [DIV_QW:0]                        rdy;
	div_state_t [DIV_LANES-1:0]             st_s  [DIV_QW];
	logic [DIV_LANES-1:0][7:0]              d_s   [DIV_QW];
	side_t                                  side_s[DIV_QW];

	assign rdy[DIV_QW] = dn_ready;
	assign up_ready    = rdy[0];

	for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
		div_state_t [DIV_LANES-1:0] cur;
		logic [DIV_LANES-1:0][7:0]  d_in;
		side_t                      side_in;
		logic                       vld_in;

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		if (k == 0) begin : g_first
			for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
				assign cur[l].rem = up_lane[l].x[DIV_XW-1:DIV_QW];
				assign cur[l].xq  = up_lane[l].x[DIV_QW-1:0];
				assign d_in[l]    = up_lane[l].d;
			end
			assign side_in = up_side;
			assign vld_in  = up_valid;
		end else begin : g_next
			assign cur     = st_s[k-1];
			assign d_in    = d_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				for (int l = 0; l < DIV_LANES; l++) begin
					st_s[k][l] <= div_step(cur[l], d_in[l]);
				end
				d_s[k]    <= d_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign dn_valid = vld_s[DIV_QW-1];
	assign dn_side  = side_s[DIV_QW-1];

	always_comb begin
		for (int l = 0; l < DIV_LANES; l++) begin
			dn_q[l] = st_s[DIV_QW-1][l].xq;
		end
	end

endmodule

`default_nettype wire
